// ----- src/eacp_pkg.sv -----
// Package for the easing animation channel pool.
// Holds command and curve codes, queue and slot record types and fixed-point constants.
// Used by the front, back and top-level modules; depends on nothing.
package eacp_pkg;

    // Command codes carried by the input channel.
    typedef enum logic [1:0] {
        CMD_CREATE   = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_STOP_ALL = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd_code;

    // Curve codes; the unnamed last code behaves as linear.
    localparam logic [2:0] CRV_LINEAR = 3'd0;
    localparam logic [2:0] CRV_IN     = 3'd1;
    localparam logic [2:0] CRV_OUT    = 3'd2;
    localparam logic [2:0] CRV_INOUT  = 3'd3;
    localparam logic [2:0] CRV_LOOP   = 3'd4;
    localparam logic [2:0] CRV_SINE   = 3'd5;
    localparam logic [2:0] CRV_STEP   = 3'd6;

    // One in Q1.16, and pi in Q2.30 for the sine table.
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Width of the reported channel count.
    localparam int LIVE_W = 5;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // A classified command waiting in the queue.
    typedef struct packed {
        t_cmd_code   cmd;
        logic [31:0] time_ms;
        logic [15:0] stop_handle;
        logic [31:0] start_value;
        logic [31:0] end_value;
        logic [23:0] period;
        logic [2:0]  curve;
        logic        loop_en;
        logic        paused;
    } t_queue_entry;

    // Stored contents of one channel slot.
    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] start_time;
        logic [23:0] period;
        logic [2:0]  curve;
        logic [31:0] from_value;
        logic [31:0] to_value;
        logic        loop_en;
        logic        paused;
    } t_slot_rec;

endpackage

// ----- src/eacp_if.sv -----
// Channel interfaces of the easing animation channel pool.
// Command input channel and result output channel, each with valid and ready.
// Depends on nothing.
interface eacp_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] time_ms;
    logic [15:0]        stop_handle;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic [23:0]        duration_ms;
    logic [2:0]         curve_kind;
    logic               loop_enable;
    logic               start_paused;

    modport source (
        output valid, command, time_ms, stop_handle, start_value, end_value,
        output duration_ms, curve_kind, loop_enable, start_paused,
        input  ready
    );
    modport sink (
        input  valid, command, time_ms, stop_handle, start_value, end_value,
        input  duration_ms, curve_kind, loop_enable, start_paused,
        output ready
    );
endinterface

interface eacp_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        handle;
    logic signed [31:0] value;
    logic               updated;
    logic [4:0]         live_count;
    logic               last;

    modport source (
        output valid, handle, value, updated, live_count, last,
        input  ready
    );
    modport sink (
        input  valid, handle, value, updated, live_count, last,
        output ready
    );
endinterface

// ----- src/eacp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the channel slot records; depends on nothing.
module eacp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/eacp_front.sv -----
// Front part of the easing animation channel pool: accepts and classifies commands.
// Holds a two-entry queue toward the back part; depends on eacp_pkg and eacp_if.
module eacp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    eacp_cmd_if.sink              i_cmd_if,
    output logic                  o_q_valid,
    output eacp_pkg::t_queue_entry o_q_entry,
    input  logic                  i_q_pop
);
    import eacp_pkg::*;

    t_queue_entry n_entry;
    t_queue_entry r_fifo [QUEUE_DEPTH];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_fill;
    logic         push;

    // Classify the incoming command; a zero period is stored as one.
    always_comb begin
        n_entry.cmd         = t_cmd_code'(i_cmd_if.command);
        n_entry.time_ms     = i_cmd_if.time_ms;
        n_entry.stop_handle = i_cmd_if.stop_handle;
        n_entry.start_value = i_cmd_if.start_value;
        n_entry.end_value   = i_cmd_if.end_value;
        n_entry.period      = (i_cmd_if.duration_ms == 24'd0) ? 24'd1 : i_cmd_if.duration_ms;
        n_entry.curve       = i_cmd_if.curve_kind;
        n_entry.loop_en     = i_cmd_if.loop_enable;
        n_entry.paused      = i_cmd_if.start_paused;
    end

    assign i_cmd_if.ready = (r_fill != 2'(QUEUE_DEPTH));
    assign push           = i_cmd_if.valid && i_cmd_if.ready;
    assign o_q_valid      = (r_fill != 2'd0);
    assign o_q_entry      = r_fifo[r_rd_ptr];

    // Queue storage, no reset on the payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_entry;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!push && i_q_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end
endmodule

// ----- src/eacp_back.sv -----
// Back part of the easing animation channel pool: executes queued commands.
// Walks the slot RAM, divides bit-serially, eases and blends; drives the result register.
// Depends on eacp_pkg, eacp_if and eacp_ram.
module eacp_back #(
    parameter int POOL_SLOTS         = 16,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  eacp_pkg::t_queue_entry i_q_entry,
    output logic                   o_q_pop,
    eacp_res_if.source             o_res_if
);
    import eacp_pkg::*;

    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int SW = $clog2(SINE_TABLE_ENTRIES);
    localparam int RW = $bits(t_slot_rec);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SLOTS - 1);
    localparam longint unsigned SINE_N    = SINE_TABLE_ENTRIES;
    localparam longint unsigned SINE_HALF = SINE_TABLE_ENTRIES / 2;

    typedef logic [16:0] t_sine_rom [SINE_TABLE_ENTRIES];

    // Half-sine table built at elaboration from the odd Taylor series.
    function automatic t_sine_rom f_build_sine();
        t_sine_rom         rom;
        longint unsigned   kk;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   acc;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
            kk = (longint'(k) > SINE_HALF) ? SINE_N - longint'(k) : longint'(k);
            x    = (PI_Q30 * kk) / SINE_N;
            x2   = (x * x) >> 30;
            // Terms x^3/3! through x^11/11!, alternating in sign.
            term = ((x * x2) >> 30) / 64'd6;
            acc  = x - term;
            term = ((term * x2) >> 30) / 64'd20;
            acc  = acc + term;
            term = ((term * x2) >> 30) / 64'd42;
            acc  = acc - term;
            term = ((term * x2) >> 30) / 64'd72;
            acc  = acc + term;
            term = ((term * x2) >> 30) / 64'd110;
            acc  = acc - term;
            acc = (acc + 64'd8192) >> 14;
            rom[k] = (acc > 64'd65536) ? ONE_Q16 : 17'(acc);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

    typedef enum logic [3:0] {
        S_IDLE, S_CREATE, S_STOP_RD, S_STOP_CHK, S_CLEAR,
        S_TK_RD, S_TK_CHK, S_TK_MOD, S_TK_FIX, S_TK_FRAC,
        S_TK_EASE, S_TK_SEL, S_TK_MUL, S_TK_OUT
    } t_state;

    t_state              r_state;
    t_queue_entry        r_cur;
    logic [AW-1:0]       r_slot;
    logic [POOL_SLOTS-1:0] r_valid;
    logic [POOL_SLOTS-1:0] r_run;
    logic [15:0]         r_next_handle;
    logic [CW-1:0]       r_count;
    logic [24:0]         r_rem;
    logic [31:0]         r_dvd;
    logic [4:0]          r_bits;
    logic                r_neg;
    logic [15:0]         r_quot;
    logic [33:0]         r_sq;
    logic [16:0]         r_sine;
    logic [16:0]         r_eased;
    logic signed [50:0]  r_prod;
    logic                r_ov;
    logic [15:0]         r_o_handle;
    logic [31:0]         r_o_value;
    logic                r_o_updated;
    logic [LIVE_W-1:0]   r_o_live;
    logic                r_o_last;

    logic                ram_we;
    t_slot_rec           ram_wdata;
    logic [RW-1:0]       ram_rdata;
    t_slot_rec           slot_rd;

    logic                out_free;
    logic                slot_last;
    logic [31:0]         elapsed;
    logic                e_neg;
    logic [31:0]         e_mag;
    logic [24:0]         period25;
    logic                e_done;
    logic                active;
    logic [15:0]         rep_handle;
    logic                stop_match;
    logic [15:0]         new_handle;
    logic [15:0]         n_next_handle;
    logic [24:0]         mod_shift;
    logic [24:0]         mod_next;
    logic [24:0]         frac_shift;
    logic                frac_ge;
    logic [24:0]         frac_next;
    logic [24:0]         fix_rem;
    logic [16:0]         sq_op;
    logic [31:0]         sine_prod;
    logic [SW-1:0]       sine_idx;
    logic [16:0]         eased_sel;
    logic signed [32:0]  diff;
    logic signed [50:0]  blend_sum;

    // Slot record storage.
    eacp_ram #(
        .WIDTH(RW),
        .DEPTH(POOL_SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(ram_wdata),
        .i_raddr(r_slot),
        .o_rdata(ram_rdata)
    );

    assign slot_rd = t_slot_rec'(ram_rdata);

    // New slot record written on a successful create.
    always_comb begin
        ram_wdata.handle     = new_handle;
        ram_wdata.start_time = r_cur.time_ms;
        ram_wdata.period     = r_cur.period;
        ram_wdata.curve      = r_cur.curve;
        ram_wdata.from_value = r_cur.start_value;
        ram_wdata.to_value   = r_cur.end_value;
        ram_wdata.loop_en    = r_cur.loop_en;
        ram_wdata.paused     = r_cur.paused;
    end

    assign out_free  = !r_ov || o_res_if.ready;
    assign slot_last = (r_slot == LAST_SLOT);
    assign ram_we    = (r_state == S_CREATE) && !r_valid[r_slot] && out_free;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;

    // Handle allocation: the counter skips zero.
    assign new_handle    = (r_next_handle == 16'd0) ? 16'd1 : r_next_handle;
    assign n_next_handle = (new_handle == 16'hFFFF) ? 16'd1 : new_handle + 16'd1;

    // Slot classification for stop and tick.
    assign stop_match = (r_cur.stop_handle != 16'd0) && r_valid[r_slot]
                        && (slot_rd.handle == r_cur.stop_handle);
    assign active     = r_valid[r_slot] && r_run[r_slot] && !slot_rd.paused;
    assign rep_handle = r_valid[r_slot] ? slot_rd.handle : 16'd0;

    // Elapsed time and the one-shot end test.
    assign elapsed  = r_cur.time_ms - slot_rd.start_time;
    assign e_neg    = elapsed[31];
    assign e_mag    = e_neg ? (32'd0 - elapsed) : elapsed;
    assign period25 = {1'b0, slot_rd.period};
    assign e_done   = !e_neg && (elapsed >= {8'd0, slot_rd.period});

    // One step of the restoring remainder and fraction divisions.
    assign mod_shift  = {r_rem[23:0], r_dvd[31]};
    assign mod_next   = (mod_shift >= period25) ? mod_shift - period25 : mod_shift;
    assign frac_shift = {r_rem[23:0], 1'b0};
    assign frac_ge    = (frac_shift >= period25);
    assign frac_next  = frac_ge ? frac_shift - period25 : frac_shift;
    assign fix_rem    = (r_neg && r_rem != 25'd0) ? period25 - r_rem : r_rem;

    // Squarer operand selected by curve.
    always_comb begin
        case (slot_rd.curve)
            CRV_OUT:   sq_op = ONE_Q16 - {1'b0, r_quot};
            CRV_INOUT: sq_op = r_quot[15] ? 17'((ONE_Q16 - {1'b0, r_quot}) << 1)
                                          : {1'b0, r_quot};
            default:   sq_op = {1'b0, r_quot};
        endcase
    end

    assign sine_prod = 32'(r_quot) * 32'(SINE_TABLE_ENTRIES);
    assign sine_idx  = sine_prod[SW+15:16];

    // Eased phase from the registered square, the table entry or the phase fraction.
    always_comb begin
        case (slot_rd.curve)
            CRV_IN:    eased_sel = 17'(r_sq >> 16);
            CRV_OUT:   eased_sel = ONE_Q16 - 17'(r_sq >> 16);
            CRV_INOUT: eased_sel = r_quot[15] ? ONE_Q16 - 17'(r_sq >> 17) : 17'(r_sq >> 15);
            CRV_SINE:  eased_sel = r_sine;
            CRV_STEP:  eased_sel = r_quot[15] ? ONE_Q16 : 17'd0;
            CRV_LINEAR, CRV_LOOP: eased_sel = {1'b0, r_quot};
            default:   eased_sel = {1'b0, r_quot};
        endcase
    end

    // Blend: from plus the floored product.
    assign diff      = 33'(signed'(slot_rd.to_value)) - 33'(signed'(slot_rd.from_value));
    assign blend_sum = 51'(signed'(slot_rd.from_value)) + (r_prod >>> 16);

    assign o_res_if.valid      = r_ov;
    assign o_res_if.handle     = r_o_handle;
    assign o_res_if.value      = r_o_value;
    assign o_res_if.updated    = r_o_updated;
    assign o_res_if.live_count = r_o_live;
    assign o_res_if.last       = r_o_last;

    // Sequencer, slot state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slot        <= '0;
            r_valid       <= '0;
            r_run         <= '0;
            r_next_handle <= 16'd1;
            r_count       <= '0;
            r_ov          <= 1'b0;
        end else begin
            if (r_ov && o_res_if.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_slot <= '0;
                    if (i_q_valid) begin
                        r_cur <= i_q_entry;
                        case (i_q_entry.cmd)
                            CMD_CREATE:   r_state <= S_CREATE;
                            CMD_STOP:     r_state <= S_STOP_RD;
                            CMD_STOP_ALL: r_state <= S_CLEAR;
                            CMD_TICK:     r_state <= S_TK_RD;
                            default:      r_state <= S_IDLE;
                        endcase
                    end
                end

                // Look for the lowest free slot, one slot a cycle.
                S_CREATE: begin
                    if (!r_valid[r_slot]) begin
                        if (out_free) begin
                            r_valid[r_slot] <= 1'b1;
                            r_run[r_slot]   <= 1'b1;
                            r_next_handle   <= n_next_handle;
                            r_count         <= r_count + 1'b1;
                            r_ov            <= 1'b1;
                            r_o_handle      <= new_handle;
                            r_o_value       <= r_cur.start_value;
                            r_o_updated     <= 1'b1;
                            r_o_live        <= LIVE_W'(r_count + 1'b1);
                            r_o_last        <= 1'b1;
                            r_state         <= S_IDLE;
                        end
                    end else if (slot_last) begin
                        if (out_free) begin
                            r_ov        <= 1'b1;
                            r_o_handle  <= 16'd0;
                            r_o_value   <= 32'd0;
                            r_o_updated <= 1'b0;
                            r_o_live    <= LIVE_W'(r_count);
                            r_o_last    <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end

                S_STOP_RD: r_state <= S_STOP_CHK;

                // Free the lowest slot holding the handle.
                S_STOP_CHK: begin
                    if (stop_match) begin
                        if (out_free) begin
                            r_valid[r_slot] <= 1'b0;
                            r_run[r_slot]   <= 1'b0;
                            r_count         <= (r_count != '0) ? r_count - 1'b1 : r_count;
                            r_ov            <= 1'b1;
                            r_o_handle      <= r_cur.stop_handle;
                            r_o_value       <= 32'd0;
                            r_o_updated     <= 1'b0;
                            r_o_live        <= LIVE_W'((r_count != '0) ? r_count - 1'b1
                                                                       : r_count);
                            r_o_last        <= 1'b1;
                            r_state         <= S_IDLE;
                        end
                    end else if (slot_last) begin
                        if (out_free) begin
                            r_ov        <= 1'b1;
                            r_o_handle  <= 16'd0;
                            r_o_value   <= 32'd0;
                            r_o_updated <= 1'b0;
                            r_o_live    <= LIVE_W'(r_count);
                            r_o_last    <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_STOP_RD;
                    end
                end

                // Free every slot; the handle counter is kept.
                S_CLEAR: begin
                    if (out_free) begin
                        r_valid     <= '0;
                        r_run       <= '0;
                        r_count     <= '0;
                        r_ov        <= 1'b1;
                        r_o_handle  <= 16'd0;
                        r_o_value   <= 32'd0;
                        r_o_updated <= 1'b0;
                        r_o_live    <= '0;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                S_TK_RD: r_state <= S_TK_CHK;

                // Classify the slot for this tick.
                S_TK_CHK: begin
                    r_bits <= 5'd0;
                    if (!active || (!slot_rd.loop_en && e_done)) begin
                        if (out_free) begin
                            r_ov        <= 1'b1;
                            r_o_handle  <= rep_handle;
                            r_o_value   <= active ? slot_rd.to_value : 32'd0;
                            r_o_updated <= active;
                            r_o_live    <= LIVE_W'(r_count);
                            r_o_last    <= slot_last;
                            if (active) begin
                                r_run[r_slot] <= 1'b0;
                            end
                            if (slot_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_slot  <= r_slot + 1'b1;
                                r_state <= S_TK_RD;
                            end
                        end
                    end else if (slot_rd.loop_en) begin
                        r_dvd   <= e_mag;
                        r_neg   <= e_neg;
                        r_rem   <= 25'd0;
                        r_state <= S_TK_MOD;
                    end else begin
                        r_rem   <= e_neg ? 25'd0 : {1'b0, elapsed[23:0]};
                        r_state <= S_TK_FRAC;
                    end
                end

                // Remainder of the elapsed magnitude, one bit a cycle.
                S_TK_MOD: begin
                    r_rem  <= mod_next;
                    r_dvd  <= {r_dvd[30:0], 1'b0};
                    r_bits <= r_bits + 5'd1;
                    if (r_bits == 5'd31) begin
                        r_state <= S_TK_FIX;
                    end
                end

                // Floored remainder for times before the start.
                S_TK_FIX: begin
                    r_rem   <= fix_rem;
                    r_bits  <= 5'd0;
                    r_state <= S_TK_FRAC;
                end

                // Phase fraction, one quotient bit a cycle.
                S_TK_FRAC: begin
                    r_rem  <= frac_next;
                    r_quot <= {r_quot[14:0], frac_ge};
                    r_bits <= r_bits + 5'd1;
                    if (r_bits == 5'd15) begin
                        r_state <= S_TK_EASE;
                    end
                end

                S_TK_EASE: begin
                    r_sq    <= 34'(sq_op) * 34'(sq_op);
                    r_sine  <= SINE_ROM[sine_idx];
                    r_state <= S_TK_SEL;
                end

                S_TK_SEL: begin
                    r_eased <= eased_sel;
                    r_state <= S_TK_MUL;
                end

                S_TK_MUL: begin
                    r_prod  <= 51'(diff) * 51'(signed'({1'b0, r_eased}));
                    r_state <= S_TK_OUT;
                end

                S_TK_OUT: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_o_handle  <= rep_handle;
                        r_o_value   <= blend_sum[31:0];
                        r_o_updated <= 1'b1;
                        r_o_live    <= LIVE_W'(r_count);
                        r_o_last    <= slot_last;
                        if (slot_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= S_TK_RD;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/easing_animation_channel_pool_top.sv -----
// Easing animation channel pool, top level. Create searches for the lowest free slot, stop
// searches the slots for the handle and stop-all frees every slot together. A tick visits each
// slot in turn: a free, paused or finished slot is reported directly, a one-shot slot runs
// the bit-serial fraction divider, a looping one also the remainder one; a held result stalls.
// One command is executed at a time; two more may wait in the input queue.
// Synchronous active-low reset frees all slots, sets the next handle to one, count to zero.
module easing_animation_channel_pool_top #(
    parameter int POOL_SLOTS         = 16,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eacp_cmd_if.sink    i_cmd_if,
    eacp_res_if.source  o_res_if
);
    import eacp_pkg::*;

    logic         q_valid;
    t_queue_entry q_entry;
    logic         q_pop;

    // Command intake and queue.
    eacp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (i_cmd_if),
        .o_q_valid(q_valid),
        .o_q_entry(q_entry),
        .i_q_pop  (q_pop)
    );

    // Command execution and results.
    eacp_back #(
        .POOL_SLOTS        (POOL_SLOTS),
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_entry(q_entry),
        .o_q_pop  (q_pop),
        .o_res_if (o_res_if)
    );
endmodule
